// ===== sv/qdd_pkg.sv =====
// ----------------------------------------------------------------------------
// qdd_pkg
// Types, codes and the gray-code table shared by the quadrature dial
// event divider.
// ----------------------------------------------------------------------------
package qdd_pkg;

  localparam int unsigned DivW   = 15;
  localparam int unsigned StepsW = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EVENT_DIVIDER = 1'b0,
    REG_MIRROR_DIR    = 1'b1
  } qdd_reg_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } qdd_cmd_e;

  typedef struct packed {
    logic cmd;
    logic pin_a;
    logic pin_b;
  } qdd_in_t;

  typedef struct packed {
    logic                     event_fired;
    logic                     event_increment;
    logic signed [StepsW-1:0] pending_steps;
    logic [1:0]               dial_position;
  } qdd_out_t;

  typedef struct packed {
    logic [DivW-1:0] event_divider;
    logic            mirror_direction;
  } qdd_cfg_t;

  // Gray index is {pin_b, pin_a}: 00->0, 01->1, 11->2, 10->3.
  function automatic logic [1:0] gray_to_pos(input logic [1:0] g);
    logic [1:0] p;
    unique case (g)
      2'b00:   p = 2'd0;
      2'b01:   p = 2'd1;
      2'b11:   p = 2'd2;
      default: p = 2'd3;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/qdd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// qdd_cfg_regs
// Configuration register file: event divider and mirror flag.
// ----------------------------------------------------------------------------
module qdd_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [qdd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qdd_pkg::CfgDataW-1:0] cfg_data_i,
  output qdd_pkg::qdd_cfg_t         cfg_o
);
  import qdd_pkg::*;

  qdd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.event_divider    <= DivW'(1);
      cfg_q.mirror_direction <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (qdd_reg_e'(cfg_idx_i))
        REG_EVENT_DIVIDER: cfg_q.event_divider    <= cfg_data_i[DivW-1:0];
        REG_MIRROR_DIR:    cfg_q.mirror_direction <= cfg_data_i[0];
        default:           ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/qdd_step.sv =====
// ----------------------------------------------------------------------------
// qdd_step
// Single-pass update: decode a pin sample or evaluate a tick against the
// divider, giving the next state and the result item.
// ----------------------------------------------------------------------------
module qdd_step #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  qdd_pkg::qdd_in_t                item_i,
  input  qdd_pkg::qdd_cfg_t               cfg_i,
  input  logic [1:0]                      last_pos_i,
  input  logic                            known_i,
  input  logic signed [COUNT_WIDTH-1:0]   count_i,
  output logic [1:0]                      last_pos_o,
  output logic                            known_o,
  output logic signed [COUNT_WIDTH-1:0]   count_o,
  output qdd_pkg::qdd_out_t               result_o
);
  import qdd_pkg::*;

  localparam int unsigned MagW = (COUNT_WIDTH > DivW) ? COUNT_WIDTH : DivW;

  localparam logic signed [COUNT_WIDTH-1:0] CountMax =
    {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CountMin =
    {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  logic [1:0]             new_pos;
  logic                   neg;
  logic [COUNT_WIDTH-1:0] mag;
  logic [MagW-1:0]        mag_ext;
  logic [MagW-1:0]        div_ext;
  logic signed [MagW:0]   count_ext;
  logic signed [MagW:0]   div_sext;
  logic signed [MagW:0]   moved;
  logic                   reach;
  logic                   fired;
  logic                   inc;
  logic signed [COUNT_WIDTH-1:0] count_n;

  assign new_pos   = gray_to_pos({item_i.pin_b, item_i.pin_a});
  assign neg       = count_i[COUNT_WIDTH-1];
  assign mag       = neg ? COUNT_WIDTH'(-count_i) : COUNT_WIDTH'(count_i);
  assign mag_ext   = MagW'(mag);
  assign div_ext   = MagW'(cfg_i.event_divider);
  assign reach     = (mag_ext >= div_ext);
  assign count_ext = {{(MagW+1-COUNT_WIDTH){count_i[COUNT_WIDTH-1]}}, count_i};
  assign div_sext  = {1'b0, div_ext};
  // Remove one divider's worth toward zero; never overshoots since mag >= div.
  assign moved     = neg ? (count_ext + div_sext) : (count_ext - div_sext);

  always_comb begin
    count_n    = count_i;
    last_pos_o = last_pos_i;
    known_o    = known_i;
    fired      = 1'b0;
    inc        = 1'b0;
    if (qdd_cmd_e'(item_i.cmd) == CMD_SAMPLE) begin
      last_pos_o = new_pos;
      known_o    = 1'b1;
      priority if (!known_i) begin
        count_n = '0;
      end else if ((last_pos_i == 2'd0 && new_pos == 2'd3) ||
                   (last_pos_i != 2'd3 && last_pos_i > new_pos) ||
                   (last_pos_i == 2'd3 && new_pos != 2'd0 && last_pos_i > new_pos)) begin
        if (count_i != CountMin) count_n = count_i - COUNT_WIDTH'(1);
      end else if ((last_pos_i == 2'd3 && new_pos == 2'd0) ||
                   (last_pos_i < new_pos)) begin
        if (count_i != CountMax) count_n = count_i + COUNT_WIDTH'(1);
      end else begin
        count_n = count_i;
      end
    end else if (reach) begin
      fired   = 1'b1;
      inc     = neg ? cfg_i.mirror_direction : !cfg_i.mirror_direction;
      count_n = moved[COUNT_WIDTH-1:0];
    end
  end

  assign count_o                  = count_n;
  assign result_o.event_fired     = fired;
  assign result_o.event_increment = inc;
  assign result_o.dial_position   = last_pos_o;

  generate
    if (COUNT_WIDTH >= StepsW) begin : g_trunc
      assign result_o.pending_steps = count_n[StepsW-1:0];
    end else begin : g_sext
      assign result_o.pending_steps =
        {{(StepsW-COUNT_WIDTH){count_n[COUNT_WIDTH-1]}}, count_n};
    end
  endgenerate

endmodule

// ===== sv/quadrature_dial_event_divider_unit.sv =====
// ----------------------------------------------------------------------------
// quadrature_dial_event_divider_unit
// x4 quadrature decoder with a pending step count and a tick-driven
// event divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one item per
//   handshake: a pin sample (cmd 0) or a periodic tick (cmd 1).
//   Output channel (out_valid_o / out_stall_i / out_item_o) returns exactly
//   one result item for every input item, in order.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i):
//   index 0 is the event divider, index 1 the mirror flag. Write only idle.
// Timing:
//   Each accepted item lands in an input register; when the result register
//   is free or being drained, the single-pass update runs and loads it, and
//   the result is offered from there. One item per cycle is sustained while
//   the receiver does not stall; the update of the count, position and known
//   registers is the only loop.
// Reset:
//   Count, position and the "position known" flag clear; divider resets to
//   1, mirror to 0. Both pipeline registers come up empty.
// Stall:
//   A stalled result holds; the input register keeps taking items while the
//   result register is free, then stall propagates back to the sender.
// ----------------------------------------------------------------------------
module quadrature_dial_event_divider_unit #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  qdd_pkg::qdd_in_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output qdd_pkg::qdd_out_t             out_item_o,
  input  logic                          cfg_we_i,
  input  logic [qdd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [qdd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import qdd_pkg::*;

  qdd_cfg_t cfg;

  logic     in_valid_q;
  qdd_in_t  in_item_q;
  logic     out_valid_q;
  qdd_out_t out_item_q;
  qdd_out_t result_d;

  logic [1:0]                    last_pos_q, last_pos_d;
  logic                          known_q, known_d;
  logic signed [COUNT_WIDTH-1:0] count_q, count_d;

  logic advance;
  logic load_in;

  qdd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  qdd_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .item_i     (in_item_q),
    .cfg_i      (cfg),
    .last_pos_i (last_pos_q),
    .known_i    (known_q),
    .count_i    (count_q),
    .last_pos_o (last_pos_d),
    .known_o    (known_d),
    .count_o    (count_d),
    .result_o   (result_d)
  );

  // Move the held item into the result register when that register is free
  // or being drained this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign load_in    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load_in) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      in_item_q <= in_item_i;
    end
  end

  // Commit state and result together so the next item sees this one's state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_pos_q  <= 2'd0;
      known_q     <= 1'b0;
      count_q     <= '0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      last_pos_q  <= last_pos_d;
      known_q     <= known_d;
      count_q     <= count_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== tb/qdd_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qdd_tb_pkg
// Expected-result tracking for the quadrature dial event divider: a
// software copy of the dial state that predicts one result per item and
// compares it with what the block returns.
// ----------------------------------------------------------------------------
package qdd_tb_pkg;
  import qdd_pkg::*;

  class dial_checker;
    localparam int CountMax   = (1 << (StepsW - 1)) - 1;
    localparam int CountMin   = -CountMax - 1;

    logic [1:0]  last_pos;
    bit          known;
    int          count;
    int unsigned divider;
    bit          mirror;
    qdd_out_t    expected_results[$];
    int          errors;

    function new();
      last_pos = 2'd0;
      known    = 1'b0;
      count    = 0;
      divider  = 1;
      mirror   = 1'b0;
      errors   = 0;
    endfunction

    function void write_register(qdd_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_EVENT_DIVIDER: divider = 32'(data[DivW-1:0]);
        REG_MIRROR_DIR:    mirror  = data[0];
        default: ;
      endcase
    endfunction

    function void step_count(int delta);
      int v;
      v = count + delta;
      if (v > CountMax) v = CountMax;
      if (v < CountMin) v = CountMin;
      count = v;
    endfunction

    // Work out the result of one accepted item and queue it.
    function void note_item(qdd_in_t it);
      qdd_out_t   res;
      logic [1:0] np;
      bit         neg;
      int         mag;
      res = '0;
      if (it.cmd == CMD_SAMPLE) begin
        case ({it.pin_b, it.pin_a})
          2'b00:   np = 2'd0;
          2'b01:   np = 2'd1;
          2'b11:   np = 2'd2;
          default: np = 2'd3;
        endcase
        if (!known) begin
          count = 0;
          known = 1'b1;
        end else if (last_pos == 2'd0 && np == 2'd3) begin
          step_count(-1);
        end else if (last_pos == 2'd3 && np == 2'd0) begin
          step_count(1);
        end else if (np > last_pos) begin
          step_count(1);
        end else if (np < last_pos) begin
          step_count(-1);
        end
        last_pos = np;
      end else begin
        neg = count < 0;
        mag = neg ? -count : count;
        if (mag >= int'(divider)) begin
          res.event_fired = 1'b1;
          if (neg) begin
            count += int'(divider);
            res.event_increment = mirror;
          end else begin
            count -= int'(divider);
            res.event_increment = !mirror;
          end
        end
      end
      res.pending_steps = count[StepsW-1:0];
      res.dial_position = last_pos;
      expected_results.push_back(res);
    endfunction

    function void flag(string field, int exp, int act);
      errors++;
      $error("%s: expected %0d, got %0d", field, exp, act);
    endfunction

    function void check_result(qdd_out_t got);
      qdd_out_t exp;
      if (expected_results.size() == 0) begin
        errors++;
        $error("result arrived with no item outstanding");
        return;
      end
      exp = expected_results.pop_front();
      if (got.event_fired !== exp.event_fired)
        flag("event_fired", exp.event_fired, got.event_fired);
      if (got.event_increment !== exp.event_increment)
        flag("event_increment", exp.event_increment, got.event_increment);
      if (got.pending_steps !== exp.pending_steps)
        flag("pending_steps", $signed(exp.pending_steps), $signed(got.pending_steps));
      if (got.dial_position !== exp.dial_position)
        flag("dial_position", exp.dial_position, got.dial_position);
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pin samples and ticks into the quadrature dial event divider under
// random sender gaps and receiver stalls, and checks every result in order
// against a predicted copy of the dial state across several register
// settings, the zero and the largest divider included.
// ----------------------------------------------------------------------------
module testbench;
  import qdd_pkg::*;
  import qdd_tb_pkg::*;

  localparam int CycleLimit   = 2_000_000;
  localparam int HoldCycles   = 64;
  localparam int WalkSteps    = 40;
  localparam int PhaseItems   = 150;
  localparam int NumPhases    = 8;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  qdd_in_t             in_item    = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  qdd_out_t            out_item;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx    = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  dial_checker sb = new();

  // Last position the stimulus walked the dial to.
  logic [1:0] dial = 2'd0;
  bit         fwd  = 1'b1;
  int         burst_left = 0;
  int         cycles = 0;
  bit         hold_off_req = 1'b0;
  bit         holding = 1'b0;

  quadrature_dial_event_divider_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check each result at the edge that accepts it; outputs are read before
  // the edge's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Receiver: stretches of random stall density, including stall-free ones,
  // plus a long hold-off on request so the block fills and stalls its input.
  initial begin
    int len;
    int pct;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
        holding = 1'b0;
      end else begin
        len = $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 25;
          2:       pct = 50;
          default: pct = 75;
        endcase
        repeat (len) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk_i);
        end
      end
    end
  end

  function automatic qdd_in_t sample_at(logic [1:0] pos);
    qdd_in_t it;
    it.cmd = CMD_SAMPLE;
    case (pos)
      2'd0:    {it.pin_b, it.pin_a} = 2'b00;
      2'd1:    {it.pin_b, it.pin_a} = 2'b01;
      2'd2:    {it.pin_b, it.pin_a} = 2'b11;
      default: {it.pin_b, it.pin_a} = 2'b10;
    endcase
    return it;
  endfunction

  // Pins ride along on ticks with random levels; the block ignores them.
  function automatic qdd_in_t tick_item();
    qdd_in_t it;
    it.cmd   = CMD_TICK;
    it.pin_a = 1'($urandom_range(0, 1));
    it.pin_b = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Present one item and hold it until the block takes it. Valid stays high
  // on return so a following item goes out back to back.
  task automatic send_item(input qdd_in_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_item(it);
  endtask

  // Send with burst pacing: after a burst, maybe drop valid for a random gap.
  task automatic send_paced(input qdd_in_t it);
    int gap;
    send_item(it);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic move_dial(input logic [1:0] pos, input bit paced);
    dial = pos;
    if (paced) send_paced(sample_at(pos));
    else send_item(sample_at(pos));
  endtask

  // Drop valid and wait until every outstanding result is back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Write both registers on consecutive edges; only call while drained.
  task automatic write_config(input logic [DivW-1:0] div, input bit mirror);
    logic [CfgDataW-1:0] mdata;
    mdata = {14'($urandom()), mirror};
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_EVENT_DIVIDER;
    cfg_data <= CfgDataW'(div);
    @(posedge clk_i);
    sb.write_register(REG_EVENT_DIVIDER, CfgDataW'(div));
    cfg_idx  <= REG_MIRROR_DIR;
    cfg_data <= mdata;
    @(posedge clk_i);
    sb.write_register(REG_MIRROR_DIR, mdata);
    cfg_we <= 1'b0;
  endtask

  // One random item: mostly single quadrature steps with some momentum,
  // then skips, repeats and ticks.
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      if ($urandom_range(0, 99) < 8) fwd = !fwd;
      move_dial(fwd ? dial + 2'd1 : dial - 2'd1, 1'b1);
    end else if (r < 66) begin
      move_dial(dial + 2'd2, 1'b1);
    end else if (r < 70) begin
      move_dial(dial, 1'b1);
    end else begin
      send_paced(tick_item());
    end
  endtask

  initial begin
    logic [DivW-1:0] div;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults are divider 1, mirror off.
    send_item(tick_item());          // tick before any sample, position 0
    move_dial(2'd2, 1'b0);           // first sample clears the count
    move_dial(2'd2, 1'b0);           // no change
    move_dial(2'd3, 1'b0);           // plain forward step
    move_dial(2'd0, 1'b0);           // wrap 3 to 0 counts up
    move_dial(2'd3, 1'b0);           // wrap 0 to 3 counts down
    move_dial(2'd1, 1'b0);           // skip downward
    move_dial(2'd3, 1'b0);           // skip upward
    send_item(tick_item());          // fires increment
    move_dial(2'd2, 1'b0);
    move_dial(2'd1, 1'b0);
    send_item(tick_item());          // fires decrement
    send_item(tick_item());
    send_item(tick_item());          // zero count, no event
    drain();

    // Divider zero: every tick fires and leaves the count alone; mirror on.
    write_config(15'd0, 1'b1);
    send_item(tick_item());
    move_dial(2'd0, 1'b0);
    send_item(tick_item());
    send_item(tick_item());
    drain();

    // Largest divider: walk the count up and back down; no tick reaches it.
    write_config(15'h7FFF, 1'b0);
    send_item(tick_item());
    repeat (WalkSteps) move_dial(dial + 2'd1, 1'b0);
    send_item(tick_item());          // far below the divider, no event
    repeat (WalkSteps) move_dial(dial - 2'd1, 1'b0);
    send_item(tick_item());
    send_item(tick_item());
    drain();

    // Random phases, each with its own register setting.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       div = 15'd0;
        1:       div = 15'h7FFF;
        2, 5:    div = 15'($urandom_range(0, 32767));
        default: div = 15'($urandom_range(1, 6));
      endcase
      write_config(div, p[0]);
      if (p == 3) begin
        // Long receiver hold-off while items keep coming back to back.
        hold_off_req = 1'b1;
        wait (holding);
        repeat (40) send_item(tick_item());
      end
      repeat (PhaseItems) random_item();
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
